### design/dhps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhps_pkg
// Shared types, register map and constants of the dithered hand pixel shader.
// ----------------------------------------------------------------------------
package dhps_pkg;

   // register map
   localparam int REG_IDX_W  = 3;
   localparam int CSR_ADDR_W = REG_IDX_W + 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [REG_IDX_W-1:0] REG_SIN_ALONG  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_COS_ALONG  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_SIN_ACROSS = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_COS_ACROSS = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_INNER_END  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_OUTER_END  = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_HALF_WIDTH = 3'd6;

   // field widths
   localparam int COORD_W  = 9;
   localparam int TRIG_W   = 17;
   localparam int END_W    = 9;
   localparam int HW_W     = 5;
   localparam int SIDE_W   = HW_W + 1;
   localparam int SCALED_W = 26;
   localparam int HW_LIM_W = 22;
   localparam int BAYER_W  = 4;

   // register reset values
   localparam logic signed [TRIG_W-1:0] RST_SIN_ALONG  = 17'sd0;
   localparam logic signed [TRIG_W-1:0] RST_COS_ALONG  = 17'sd65535;
   localparam logic signed [TRIG_W-1:0] RST_SIN_ACROSS = 17'sd65535;
   localparam logic signed [TRIG_W-1:0] RST_COS_ACROSS = 17'sd0;
   localparam logic signed [END_W-1:0]  RST_INNER_END  = 9'sd0;
   localparam logic signed [END_W-1:0]  RST_OUTER_END  = 9'sd0;
   localparam logic [HW_W-1:0]          RST_HALF_WIDTH = 5'd0;

   // grain hash
   localparam logic [31:0] HASH_MUL_X  = 32'd1664525;
   localparam logic [31:0] HASH_MUL_Y  = 32'd22695477;
   localparam int          HASH_SHIFT  = 13;
   localparam int          GRAIN_BITS  = 8;
   localparam int          HASH_W      = HASH_SHIFT + GRAIN_BITS;
   localparam int          GRAIN_LIMIT = 8;

   // full coverage level
   localparam int FULL_COVER = 16;

   localparam logic [BAYER_W-1:0] BAYER [4][4] = '{
      '{4'd0,  4'd8,  4'd2,  4'd10},
      '{4'd12, 4'd4,  4'd14, 4'd6},
      '{4'd3,  4'd11, 4'd1,  4'd9},
      '{4'd15, 4'd7,  4'd13, 4'd5}
   };

   typedef struct packed {
      logic [COORD_W-1:0] px;
      logic [COORD_W-1:0] py;
   } req_type;

   typedef struct packed {
      logic draw;
      logic light_grain;
   } rsp_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0]   sin_along;
      logic signed [TRIG_W-1:0]   cos_along;
      logic signed [TRIG_W-1:0]   sin_across;
      logic signed [TRIG_W-1:0]   cos_across;
      logic signed [SCALED_W-1:0] lo_ts;
      logic signed [SCALED_W-1:0] hi_ts;
      logic [HW_LIM_W-1:0]        hw_lim;
      logic                       side_en;
      logic [HW_W-1:0]            zone;
   } cfg_type;

endpackage
`default_nettype wire

### design/dithered_hand_pixel_shader.sv
`timescale 1ns / 1ps
`default_nettype none
// throughput: one request per cycle; a stalled response holds only the
//   stages behind it, bubbles in the pipe keep being filled
// reset: synchronous, clears all stage valid bits and the hand registers
//   to their defaults; pready is always high
// ----------------------------------------------------------------------------
// dithered_hand_pixel_shader
// Per-pixel coverage and 4x4 ordered dither for one anti-aliased clock hand.
// ----------------------------------------------------------------------------
module dithered_hand_pixel_shader #(
   parameter int CENTER     = 130,
   parameter int TRIG_SCALE = 65535,
   parameter int FADE_LEN   = 10,
   parameter int SOLID_HALF = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  dhps_pkg::req_type               req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output dhps_pkg::rsp_type               rsp_payload,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [dhps_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [dhps_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [dhps_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import dhps_pkg::*;

   localparam int DW  = $clog2((CENTER > 512) ? CENTER : 512) + 1;
   localparam int AW  = DW + TRIG_W + 1;
   localparam int TW  = $clog2(TRIG_SCALE + 1);
   localparam int SLW = SIDE_W + TW;
   localparam int KW  = $clog2(FADE_LEN * TRIG_SCALE + 1);

   cfg_type              cfg;
   logic                 mid_valid, mid_ready;
   logic signed [AW-1:0] mid_along, mid_across;
   logic [SLW-1:0]       mid_side_lim;
   logic [KW-1:0]        mid_kend;
   logic                 mid_light;

   dhps_csr #(
      .TRIG_SCALE (TRIG_SCALE),
      .SOLID_HALF (SOLID_HALF)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dhps_proj #(
      .CENTER     (CENTER),
      .TRIG_SCALE (TRIG_SCALE),
      .FADE_LEN   (FADE_LEN),
      .SOLID_HALF (SOLID_HALF)
   ) u_proj (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .in_req       (req_payload),
      .cfg          (cfg),
      .out_valid    (mid_valid),
      .out_ready    (mid_ready),
      .out_along    (mid_along),
      .out_across   (mid_across),
      .out_side_lim (mid_side_lim),
      .out_kend     (mid_kend),
      .out_light    (mid_light)
   );

   dhps_cover #(
      .CENTER     (CENTER),
      .TRIG_SCALE (TRIG_SCALE),
      .FADE_LEN   (FADE_LEN)
   ) u_cover (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (mid_valid),
      .in_ready    (mid_ready),
      .in_along    (mid_along),
      .in_across   (mid_across),
      .in_side_lim (mid_side_lim),
      .in_kend     (mid_kend),
      .in_light    (mid_light),
      .cfg         (cfg),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_rsp     (rsp_payload)
   );

endmodule
`default_nettype wire

### design/dhps_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhps_csr
// Hand registers on the APB-style port, plus the scaled limits derived from them.
// ----------------------------------------------------------------------------
module dhps_csr #(
   parameter int TRIG_SCALE = 65535,
   parameter int SOLID_HALF = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [dhps_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [dhps_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [dhps_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output dhps_pkg::cfg_type                   cfg
);
   import dhps_pkg::*;

   logic signed [TRIG_W-1:0]   sin_along_ff, cos_along_ff, sin_across_ff, cos_across_ff;
   logic signed [END_W-1:0]    inner_end_ff, outer_end_ff;
   logic [HW_W-1:0]            half_width_ff;
   logic [REG_IDX_W-1:0]       reg_idx;
   logic                       wr_en;
   logic [SIDE_W-1:0]          hw_p1;

   logic signed [SCALED_W-1:0] lo_ts_in, lo_ts_ff, hi_ts_in, hi_ts_ff;
   logic [HW_LIM_W-1:0]        hw_lim_in, hw_lim_ff;
   logic                       side_en_in, side_en_ff;
   logic [HW_W-1:0]            zone_in, zone_ff;

   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel & penable & pwrite & pready;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sin_along_ff  <= RST_SIN_ALONG;
         cos_along_ff  <= RST_COS_ALONG;
         sin_across_ff <= RST_SIN_ACROSS;
         cos_across_ff <= RST_COS_ACROSS;
         inner_end_ff  <= RST_INNER_END;
         outer_end_ff  <= RST_OUTER_END;
         half_width_ff <= RST_HALF_WIDTH;
      end else if (wr_en) begin
         case (reg_idx)
            REG_SIN_ALONG:  sin_along_ff  <= pwdata[TRIG_W-1:0];
            REG_COS_ALONG:  cos_along_ff  <= pwdata[TRIG_W-1:0];
            REG_SIN_ACROSS: sin_across_ff <= pwdata[TRIG_W-1:0];
            REG_COS_ACROSS: cos_across_ff <= pwdata[TRIG_W-1:0];
            REG_INNER_END:  inner_end_ff  <= pwdata[END_W-1:0];
            REG_OUTER_END:  outer_end_ff  <= pwdata[END_W-1:0];
            REG_HALF_WIDTH: half_width_ff <= pwdata[HW_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_SIN_ALONG:  prdata = CSR_DATA_W'(sin_along_ff);
         REG_COS_ALONG:  prdata = CSR_DATA_W'(cos_along_ff);
         REG_SIN_ACROSS: prdata = CSR_DATA_W'(sin_across_ff);
         REG_COS_ACROSS: prdata = CSR_DATA_W'(cos_across_ff);
         REG_INNER_END:  prdata = CSR_DATA_W'(inner_end_ff);
         REG_OUTER_END:  prdata = CSR_DATA_W'(outer_end_ff);
         REG_HALF_WIDTH: prdata = CSR_DATA_W'(half_width_ff);
         default:        prdata = '0;
      endcase
   end

   // scaled span ends, width limit and side fade zone
   assign hw_p1      = SIDE_W'(half_width_ff) + SIDE_W'(1);
   assign lo_ts_in   = SCALED_W'(inner_end_ff) * SCALED_W'(TRIG_SCALE);
   assign hi_ts_in   = SCALED_W'(outer_end_ff) * SCALED_W'(TRIG_SCALE);
   assign hw_lim_in  = HW_LIM_W'(hw_p1) * HW_LIM_W'(TRIG_SCALE);
   assign side_en_in = half_width_ff > HW_W'(SOLID_HALF);
   assign zone_in    = half_width_ff - HW_W'(SOLID_HALF);

   always_ff @(posedge clock) begin
      lo_ts_ff   <= lo_ts_in;
      hi_ts_ff   <= hi_ts_in;
      hw_lim_ff  <= hw_lim_in;
      side_en_ff <= side_en_in;
      zone_ff    <= zone_in;
   end

   assign cfg.sin_along  = sin_along_ff;
   assign cfg.cos_along  = cos_along_ff;
   assign cfg.sin_across = sin_across_ff;
   assign cfg.cos_across = cos_across_ff;
   assign cfg.lo_ts      = lo_ts_ff;
   assign cfg.hi_ts      = hi_ts_ff;
   assign cfg.hw_lim     = hw_lim_ff;
   assign cfg.side_en    = side_en_ff;
   assign cfg.zone       = zone_ff;

endmodule
`default_nettype wire

### design/dhps_proj.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhps_proj
// Three-stage front end: center offsets, axis projections, fade limits, grain.
// ----------------------------------------------------------------------------
module dhps_proj #(
   parameter int  CENTER     = 130,
   parameter int  TRIG_SCALE = 65535,
   parameter int  FADE_LEN   = 10,
   parameter int  SOLID_HALF = 4,
   localparam int DW  = $clog2((CENTER > 512) ? CENTER : 512) + 1,
   localparam int PW  = DW + dhps_pkg::TRIG_W,
   localparam int AW  = PW + 1,
   localparam int TW  = $clog2(TRIG_SCALE + 1),
   localparam int SLW = dhps_pkg::SIDE_W + TW,
   localparam int KW  = $clog2(FADE_LEN * TRIG_SCALE + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  dhps_pkg::req_type    in_req,
   input  dhps_pkg::cfg_type    cfg,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic signed [AW-1:0] out_along,
   output logic signed [AW-1:0] out_across,
   output logic [SLW-1:0]       out_side_lim,
   output logic [KW-1:0]        out_kend,
   output logic                 out_light
);
   import dhps_pkg::*;

   function automatic logic [KW-1:0] kend_ts(int b);
      return KW'((((b + 1) * FADE_LEN + FULL_COVER - 1) / FULL_COVER) * TRIG_SCALE);
   endfunction

   logic [KW-1:0] kend_tab [FULL_COVER];

   for (genvar g = 0; g < FULL_COVER; g++) begin : g_kend
      assign kend_tab[g] = kend_ts(g);
   end

   logic rdy1, rdy2, rdy3;
   logic v1_ff, v2_ff, v3_ff;

   // stage 1
   logic signed [DW-1:0] dx1_in, dy1_in, dx1_ff, dy1_ff;
   logic [BAYER_W-1:0]   bay1_in, bay1_ff;
   logic [HASH_W-1:0]    hx1_in, hy1_in, hx1_ff, hy1_ff;

   // stage 2
   logic signed [PW-1:0] p_sa2_in, p_ca2_in, p_sx2_in, p_cx2_in;
   logic signed [PW-1:0] p_sa2_ff, p_ca2_ff, p_sx2_ff, p_cx2_ff;
   logic [HASH_W-1:0]    hsum;
   logic [GRAIN_BITS-1:0] hmix;
   logic [BAYER_W:0]     fade_wt;
   logic [2*HW_W-1:0]    side_m;
   logic [SIDE_W-1:0]    dside2_in, dside2_ff;
   logic [KW-1:0]        kend2_in, kend2_ff;
   logic                 light2_in, light2_ff;

   // stage 3
   logic signed [AW-1:0] along3_in, across3_in, along3_ff, across3_ff;
   logic [SLW-1:0]       side_lim3_in, side_lim3_ff;
   logic [KW-1:0]        kend3_ff;
   logic                 light3_ff;

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   // offsets from screen center, dither entry, hash partial products
   assign dx1_in  = $signed(DW'(in_req.px)) - $signed(DW'(CENTER));
   assign dy1_in  = $signed(DW'(in_req.py)) - $signed(DW'(CENTER));
   assign bay1_in = BAYER[in_req.py[1:0]][in_req.px[1:0]];
   assign hx1_in  = HASH_W'(HASH_W'(in_req.px) * HASH_MUL_X[HASH_W-1:0]);
   assign hy1_in  = HASH_W'(HASH_W'(in_req.py) * HASH_MUL_Y[HASH_W-1:0]);

   always_ff @(posedge clock) begin
      if (rdy1) begin
         dx1_ff  <= dx1_in;
         dy1_ff  <= dy1_in;
         bay1_ff <= bay1_in;
         hx1_ff  <= hx1_in;
         hy1_ff  <= hy1_in;
      end
   end

   // projections, side fade bound in pixels, end fade bound, grain bit
   assign p_sa2_in = PW'(dx1_ff) * PW'(cfg.sin_along);
   assign p_ca2_in = PW'(dy1_ff) * PW'(cfg.cos_along);
   assign p_sx2_in = PW'(dx1_ff) * PW'(cfg.sin_across);
   assign p_cx2_in = PW'(dy1_ff) * PW'(cfg.cos_across);

   assign hsum      = hx1_ff + hy1_ff;
   assign hmix      = hsum[GRAIN_BITS-1:0] ^ hsum[HASH_SHIFT +: GRAIN_BITS];
   assign light2_in = hmix < GRAIN_BITS'(GRAIN_LIMIT);

   assign fade_wt   = (BAYER_W + 1)'(FULL_COVER) - (BAYER_W + 1)'(bay1_ff);
   assign side_m    = (2 * HW_W)'(fade_wt) * (2 * HW_W)'(cfg.zone);
   assign dside2_in = SIDE_W'(SOLID_HALF)
                    + SIDE_W'((side_m + (2 * HW_W)'(FULL_COVER - 1)) >> BAYER_W);
   assign kend2_in  = kend_tab[bay1_ff];

   always_ff @(posedge clock) begin
      if (rdy2) begin
         p_sa2_ff  <= p_sa2_in;
         p_ca2_ff  <= p_ca2_in;
         p_sx2_ff  <= p_sx2_in;
         p_cx2_ff  <= p_cx2_in;
         dside2_ff <= dside2_in;
         kend2_ff  <= kend2_in;
         light2_ff <= light2_in;
      end
   end

   // axis distances and scaled side fade bound
   assign along3_in    = AW'(p_sa2_ff) - AW'(p_ca2_ff);
   assign across3_in   = AW'(p_sx2_ff) - AW'(p_cx2_ff);
   assign side_lim3_in = SLW'(dside2_ff) * SLW'(TRIG_SCALE);

   always_ff @(posedge clock) begin
      if (rdy3) begin
         along3_ff    <= along3_in;
         across3_ff   <= across3_in;
         side_lim3_ff <= side_lim3_in;
         kend3_ff     <= kend2_ff;
         light3_ff    <= light2_ff;
      end
   end

   assign out_valid    = v3_ff;
   assign out_along    = along3_ff;
   assign out_across   = across3_ff;
   assign out_side_lim = side_lim3_ff;
   assign out_kend     = kend3_ff;
   assign out_light    = light3_ff;

endmodule
`default_nettype wire

### design/dhps_cover.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhps_cover
// Two-stage back end: span and width tests, fade against dither, output register.
// ----------------------------------------------------------------------------
module dhps_cover #(
   parameter int  CENTER     = 130,
   parameter int  TRIG_SCALE = 65535,
   parameter int  FADE_LEN   = 10,
   localparam int DW  = $clog2((CENTER > 512) ? CENTER : 512) + 1,
   localparam int PW  = DW + dhps_pkg::TRIG_W,
   localparam int AW  = PW + 1,
   localparam int CW  = AW + 1,
   localparam int TW  = $clog2(TRIG_SCALE + 1),
   localparam int SLW = dhps_pkg::SIDE_W + TW,
   localparam int KW  = $clog2(FADE_LEN * TRIG_SCALE + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic signed [AW-1:0] in_along,
   input  logic signed [AW-1:0] in_across,
   input  logic [SLW-1:0]       in_side_lim,
   input  logic [KW-1:0]        in_kend,
   input  logic                 in_light,
   input  dhps_pkg::cfg_type    cfg,
   output logic                 out_valid,
   input  logic                 out_ready,
   output dhps_pkg::rsp_type    out_rsp
);
   import dhps_pkg::*;

   logic rdy4, rdy5;
   logic v4_ff, v5_ff;

   logic [AW-1:0]        mag4_in, mag4_ff;
   logic signed [CW-1:0] dtail4_in, dtip4_in, dtail4_ff, dtip4_ff;
   logic [SLW-1:0]       side_lim4_ff;
   logic [KW-1:0]        kend4_ff;
   logic                 light4_ff;

   logic                 in_span, width_ok, side_ok, end_ok, draw_in;
   rsp_type              rsp_in, rsp_ff;

   assign rdy5     = !v5_ff || out_ready;
   assign rdy4     = !v4_ff || rdy5;
   assign in_ready = rdy4;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy4) v4_ff <= in_valid;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   // magnitude across, distances to both span ends
   assign mag4_in   = in_across[AW-1] ? AW'(-in_across) : AW'(in_across);
   assign dtail4_in = CW'(in_along) - CW'(cfg.lo_ts);
   assign dtip4_in  = CW'(cfg.hi_ts) - CW'(in_along);

   always_ff @(posedge clock) begin
      if (rdy4) begin
         mag4_ff      <= mag4_in;
         dtail4_ff    <= dtail4_in;
         dtip4_ff     <= dtip4_in;
         side_lim4_ff <= in_side_lim;
         kend4_ff     <= in_kend;
         light4_ff    <= in_light;
      end
   end

   // coverage above dither entry, as compares against scaled bounds
   assign in_span  = !dtail4_ff[CW-1] && !dtip4_ff[CW-1];
   assign width_ok = CW'(mag4_ff) < CW'(cfg.hw_lim);
   assign side_ok  = !cfg.side_en || (CW'(mag4_ff) < CW'(side_lim4_ff));
   assign end_ok   = ($unsigned(dtail4_ff) >= CW'(kend4_ff))
                  && ($unsigned(dtip4_ff) >= CW'(kend4_ff));
   assign draw_in  = in_span && width_ok && side_ok && end_ok;

   assign rsp_in.draw        = draw_in;
   assign rsp_in.light_grain = draw_in && light4_ff;

   always_ff @(posedge clock) begin
      if (rdy5) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = v5_ff;
   assign out_rsp   = rsp_ff;

endmodule
`default_nettype wire

### design/dhps_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhps_checker
// Port-level checks of the shader pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module dhps_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input dhps_pkg::rsp_type rsp_payload
);
   import dhps_pkg::*;

   // held response stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // output stage empty after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // an empty or draining output never blocks new requests
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("request blocked with free output");

   // grain only on drawn pixels
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.draw || !rsp_payload.light_grain)
      else $error("grain set on undrawn pixel");

   // request accept is only a reference for the check below
   logic req_seen;
   assign req_seen = req_valid && req_ready;

   assert property (@(posedge clock) disable iff (reset)
      req_seen |-> req_ready)
      else $error("accept without ready");

endmodule

bind dithered_hand_pixel_shader dhps_checker u_dhps_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
`default_nettype wire

### dv/tb_dithered_hand_pixel_shader.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dithered_hand_pixel_shader
// Loads hand geometry over the register port, sends pixel requests under
// random valid gaps and response stalls, predicts draw and grain for every
// pixel from the loaded registers and checks each response in order.
// ----------------------------------------------------------------------------
module tb_dithered_hand_pixel_shader;
   import dhps_pkg::*;

   localparam longint CENTER_POS = 130;
   localparam longint TRIG_FULL  = 65535;
   localparam longint FADE_SPAN  = 10;
   localparam longint SOLID_SPAN = 4;
   // 4x4 ordered dither levels, entry (row*4 + col) at nibble index
   localparam logic [63:0] DITHER_NIBBLES = 64'h5D7F_91B3_6E4C_A280;
   localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;
   localparam int PIPE_DEPTH  = 5;
   localparam int CYCLE_LIMIT = 1000000;
   localparam real TWO_PI = 6.283185307179586;

   typedef struct {
      req_type pix;
      rsp_type shade;
   } shade_expect_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   rsp_type               rsp_payload;
   logic                  psel        = 1'b0;
   logic                  penable     = 1'b0;
   logic                  pwrite      = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr       = '0;
   logic [CSR_DATA_W-1:0] pwdata      = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // shadow copy of the hand registers
   longint hand_sin_along  = 0;
   longint hand_cos_along  = 65535;
   longint hand_sin_across = 65535;
   longint hand_cos_across = 0;
   longint hand_inner      = 0;
   longint hand_outer      = 0;
   longint hand_half       = 0;

   shade_expect_type expected_shades[$];
   shade_expect_type oldest_shade;
   int            mismatches  = 0;
   int            cycle_count = 0;
   int            stall_left  = 0;
   bit            quiet_mode  = 1'b0;

   dithered_hand_pixel_shader dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_type shade_pixel(req_type pix);
      longint  dx, dy, lo, hi, along, across, perp_px;
      longint  d_tail, d_tip, span_px, thr, zone, t, cell_level;
      logic [31:0] hx, hy, h;
      int      cell_idx;
      rsp_type shade;
      shade = '0;
      dx = pix.px;
      dx = dx - CENTER_POS;
      dy = pix.py;
      dy = dy - CENTER_POS;
      lo = hand_inner * TRIG_FULL;
      hi = hand_outer * TRIG_FULL;
      along = dx * hand_sin_along - dy * hand_cos_along;
      if (along < lo || along > hi) return shade;
      across = dx * hand_sin_across - dy * hand_cos_across;
      if (across < 0) across = -across;
      perp_px = across / TRIG_FULL;
      if (perp_px > hand_half) return shade;
      d_tail = (along - lo) / TRIG_FULL;
      d_tip = (hi - along) / TRIG_FULL;
      span_px = (d_tail < d_tip) ? d_tail : d_tip;
      thr = 16;
      zone = hand_half - SOLID_SPAN;
      // side fade only on hands wider than the solid core
      if (perp_px > SOLID_SPAN && zone > 0) begin
         t = 16 - (perp_px - SOLID_SPAN) * 16 / zone;
         if (t < thr) thr = t;
      end
      if (span_px < FADE_SPAN) begin
         t = span_px * 16 / FADE_SPAN;
         if (t < thr) thr = t;
      end
      if (thr <= 0) return shade;
      cell_idx = {pix.py[1:0], pix.px[1:0]};
      cell_level = DITHER_NIBBLES[cell_idx*4 +: 4];
      if (thr < 16 && cell_level >= thr) return shade;
      hx = pix.px;
      hy = pix.py;
      h = hx * 32'd1664525 + hy * 32'd22695477;
      h = h ^ (h >> 13);
      shade.draw = 1'b1;
      shade.light_grain = (h[7:0] < 8'd8);
      return shade;
   endfunction

   function automatic void shadow_write(logic [REG_IDX_W-1:0] idx,
                                        logic [CSR_DATA_W-1:0] val);
      case (idx)
         REG_SIN_ALONG:  hand_sin_along  = $signed(val[TRIG_W-1:0]);
         REG_COS_ALONG:  hand_cos_along  = $signed(val[TRIG_W-1:0]);
         REG_SIN_ACROSS: hand_sin_across = $signed(val[TRIG_W-1:0]);
         REG_COS_ACROSS: hand_cos_across = $signed(val[TRIG_W-1:0]);
         REG_INNER_END:  hand_inner      = $signed(val[END_W-1:0]);
         REG_OUTER_END:  hand_outer      = $signed(val[END_W-1:0]);
         REG_HALF_WIDTH: hand_half       = val[HW_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic int pick_gap();
      int roll;
      if (quiet_mode) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   function automatic int pick_stall();
      int roll;
      if (quiet_mode) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatches++;
   endtask

   task automatic csr_write(input logic [REG_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      shadow_write(idx, val);
      @(posedge clock);
   endtask

   task automatic load_hand(input int sa, input int ca, input int sc, input int cc,
                            input int inner, input int outer, input int hw);
      csr_write(REG_SIN_ALONG, sa);
      csr_write(REG_COS_ALONG, ca);
      csr_write(REG_SIN_ACROSS, sc);
      csr_write(REG_COS_ACROSS, cc);
      csr_write(REG_INNER_END, inner);
      csr_write(REG_OUTER_END, outer);
      csr_write(REG_HALF_WIDTH, hw);
   endtask

   task automatic send_pixel(input int x, input int y);
      int               gap;
      req_type          pix;
      shade_expect_type entry;
      gap = pick_gap();
      pix.px = x[COORD_W-1:0];
      pix.py = y[COORD_W-1:0];
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= pix;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      entry.pix = pix;
      entry.shade = shade_pixel(pix);
      expected_shades.push_back(entry);
   endtask

   // hold requests until every pending response is back
   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_shades.size() != 0);
   endtask

   task automatic settle_pipe();
      drain_responses();
      repeat (PIPE_DEPTH) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_shades.size() == 0) begin
            report_mismatch($sformatf("unexpected response draw %0b grain %0b",
                                      rsp_payload.draw, rsp_payload.light_grain));
         end else begin
            oldest_shade = expected_shades.pop_front();
            if (rsp_payload.draw !== oldest_shade.shade.draw)
               report_mismatch($sformatf("draw got %0b want %0b px %0d py %0d",
                                         rsp_payload.draw, oldest_shade.shade.draw,
                                         oldest_shade.pix.px, oldest_shade.pix.py));
            if (rsp_payload.light_grain !== oldest_shade.shade.light_grain)
               report_mismatch($sformatf("grain got %0b want %0b px %0d py %0d",
                                         rsp_payload.light_grain,
                                         oldest_shade.shade.light_grain,
                                         oldest_shade.pix.px, oldest_shade.pix.py));
         end
      end
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         stall_left = pick_stall();
         rsp_ready <= (stall_left == 0);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic test_reset_defaults();
      send_pixel(130, 130);
      send_pixel(0, 0);
      send_pixel(511, 511);
      settle_pipe();
   endtask

   // upright hand: along = 130 - py, across = px - 130
   task automatic test_upright_hand();
      load_hand(0, 65535, 65535, 0, -20, 100, 10);
      send_pixel(130, 30);
      send_pixel(130, 80);
      send_pixel(135, 80);
      send_pixel(140, 80);
      send_pixel(141, 80);
      send_pixel(130, 125);
      send_pixel(130, 145);
      send_pixel(131, 146);
      send_pixel(132, 147);
      send_pixel(130, 151);
      settle_pipe();
   endtask

   task automatic test_inverted_ends();
      csr_write(REG_INNER_END, 50);
      csr_write(REG_OUTER_END, 10);
      send_pixel(130, 100);
      send_pixel(130, 120);
      settle_pipe();
   endtask

   task automatic test_narrow_hand();
      csr_write(REG_INNER_END, -20);
      csr_write(REG_OUTER_END, 100);
      csr_write(REG_HALF_WIDTH, 3);
      send_pixel(133, 80);
      send_pixel(134, 80);
      settle_pipe();
      csr_write(REG_HALF_WIDTH, 4);
      send_pixel(134, 81);
      settle_pipe();
   endtask

   task automatic test_register_extremes();
      load_hand(-65536, 65535, -65536, 65535, -256, 255, 31);
      send_pixel(0, 511);
      send_pixel(511, 0);
      send_pixel(259, 259);
      send_pixel(0, 0);
      settle_pipe();
   endtask

   task automatic test_unused_register();
      load_hand(0, 65535, 65535, 0, -20, 100, 10);
      csr_write(REG_UNUSED, 32'hFFFF_FFFF);
      send_pixel(130, 80);
      send_pixel(128, 131);
      settle_pipe();
   endtask

   task automatic test_random_hands();
      real theta, s, c, r, w;
      int  phase, k, inner, outer, hw, sa, ca, x, y, swap;
      for (phase = 0; phase < 15; phase++) begin
         theta = TWO_PI * $urandom_range(0, 3599) / 3600.0;
         s = $sin(theta);
         c = $cos(theta);
         sa = $rtoi(65535.0 * s);
         ca = $rtoi(65535.0 * c);
         inner = $urandom_range(0, 190) - 130;
         outer = inner + $urandom_range(0, 130 - inner);
         if (phase == 7) begin
            swap = inner;
            inner = outer + 5;
            outer = swap;
         end
         hw = $urandom_range(0, 31);
         if (phase == 0) hw = 0;
         if (phase == 1) hw = 31;
         quiet_mode = (phase == 5 || phase == 9);
         load_hand(sa, ca, ca, -sa, inner, outer, hw);
         for (k = 0; k < 100; k++) begin
            if (phase == 3 && k == 50) drain_responses();
            if ($urandom_range(0, 99) < 85) begin
               r = inner - 3 + (outer - inner + 6) * ($urandom_range(0, 10000) / 10000.0);
               w = (hw + 3) * (2.0 * $urandom_range(0, 10000) / 10000.0 - 1.0);
               x = $rtoi(130.5 + r * s + w * c);
               y = $rtoi(130.5 - r * c + w * s);
               if (x < 0) x = 0;
               if (x > 511) x = 511;
               if (y < 0) y = 0;
               if (y > 511) y = 511;
            end else if ($urandom_range(0, 1) == 0) begin
               x = $urandom_range(0, 511);
               y = $urandom_range(0, 511);
            end else begin
               x = $urandom_range(0, 259);
               y = $urandom_range(0, 259);
            end
            send_pixel(x, y);
         end
         settle_pipe();
      end
      quiet_mode = 1'b0;
   endtask

   task automatic test_raw_registers();
      int phase, k;
      for (phase = 0; phase < 4; phase++) begin
         load_hand($urandom(), $urandom(), $urandom(), $urandom(),
                   $urandom(), $urandom(), $urandom());
         for (k = 0; k < 50; k++)
            send_pixel($urandom_range(0, 511), $urandom_range(0, 511));
         settle_pipe();
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_upright_hand();
      test_inverted_ends();
      test_narrow_hand();
      test_register_extremes();
      test_unused_register();
      test_random_hands();
      test_raw_registers();
      settle_pipe();
      repeat (PIPE_DEPTH * 4) @(posedge clock);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
